[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// Next-cycle implication, ignored while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

[hdl/plsl_pkg.sv]
package plsl_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] MODE_AMBIENT = 2'd1;
    localparam logic [1:0] MODE_DIFFUSE = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_AMBIENT  = 3'd1;
    localparam logic [2:0] REG_DIFFUSE  = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_LIGHTPOS = 3'd4;
    localparam logic [2:0] REG_ROW_X    = 3'd5;
    localparam logic [2:0] REG_ROW_Y    = 3'd6;
    localparam logic [2:0] REG_ROW_Z    = 3'd7;

    localparam logic [63:0] ROW_X_RESET = 64'd16384;
    localparam logic [63:0] ROW_Y_RESET = 64'd16384 << 16;
    localparam logic [63:0] ROW_Z_RESET = 64'd16384 << 32;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_AMBIENT,
        OP_DIFFUSE
    } t_op;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      ambient;
        logic [31:0]      diffuse;
        logic [15:0]      radius;
        logic [47:0]      light_pos;
        logic [2:0][63:0] rows;
    } t_cfg;

    // Positions z,y,x from high to low; colors byte 0 is primary red.
    typedef struct packed {
        t_op         op;
        logic [47:0] pos;
        logic [63:0] col;
    } t_item;

endpackage

[hdl/particle_simple_light_color.sv]
// Particle lighting unit: lights a primary and a secondary RGBA color per
// particle by the ambient color alone or, in diffuse mode, by a blend of
// diffuse and ambient set by distance to the light, or passes them through.
// Requests enter on i_valid/o_ready with the position and both colors; the
// lit colors leave on o_valid/i_ready. One request can be taken per clock
// while o_ready is high. From acceptance a request passes the input
// register, the queue and a 36-stage back pipeline before reaching o_valid;
// the depth is set by the 20 square-root steps and 9 divide steps.
// A four-entry queue sits between the input register and the pipeline. If
// the receiver holds i_ready low the whole pipeline freezes with its result
// held on the outputs, and requests keep being taken until the queue fills.
// Registers sit on the APB port at byte address 8*index; program them only
// while no request is in flight. Synchronous reset empties the pipeline and
// loads mode 0 (colors passed through), white ambient and an identity matrix.
module particle_simple_light_color #(
    parameter int QDEPTH = plsl_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [7:0]         i_pri_red,
    input  logic [7:0]         i_pri_green,
    input  logic [7:0]         i_pri_blue,
    input  logic [7:0]         i_pri_alpha,
    input  logic [7:0]         i_sec_red,
    input  logic [7:0]         i_sec_green,
    input  logic [7:0]         i_sec_blue,
    input  logic [7:0]         i_sec_alpha,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_lit_pri_red,
    output logic [7:0]         o_lit_pri_green,
    output logic [7:0]         o_lit_pri_blue,
    output logic [7:0]         o_lit_pri_alpha,
    output logic [7:0]         o_lit_sec_red,
    output logic [7:0]         o_lit_sec_green,
    output logic [7:0]         o_lit_sec_blue,
    output logic [7:0]         o_lit_sec_alpha
);
    import plsl_pkg::*;

    t_cfg        r_cfg;
    t_item       f_item;
    t_item       q_item;
    logic        f_valid;
    logic        f_ready;
    logic        q_valid;
    logic        q_ready;
    logic [63:0] col_in;
    logic [63:0] col_out;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= 2'd0;
            r_cfg.ambient   <= 32'hFFFF_FFFF;
            r_cfg.diffuse   <= 32'd0;
            r_cfg.radius    <= 16'd0;
            r_cfg.light_pos <= 48'd0;
            r_cfg.rows[0]   <= ROW_X_RESET;
            r_cfg.rows[1]   <= ROW_Y_RESET;
            r_cfg.rows[2]   <= ROW_Z_RESET;
        end else if (wr_en) begin
            unique case (paddr[5:3])
                REG_MODE:     r_cfg.mode      <= pwdata[1:0];
                REG_AMBIENT:  r_cfg.ambient   <= pwdata[31:0];
                REG_DIFFUSE:  r_cfg.diffuse   <= pwdata[31:0];
                REG_RADIUS:   r_cfg.radius    <= pwdata[15:0];
                REG_LIGHTPOS: r_cfg.light_pos <= pwdata[47:0];
                REG_ROW_X:    r_cfg.rows[0]   <= pwdata;
                REG_ROW_Y:    r_cfg.rows[1]   <= pwdata;
                REG_ROW_Z:    r_cfg.rows[2]   <= pwdata;
                default:      r_cfg.mode      <= r_cfg.mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_MODE:     prdata = 64'(r_cfg.mode);
            REG_AMBIENT:  prdata = 64'(r_cfg.ambient);
            REG_DIFFUSE:  prdata = 64'(r_cfg.diffuse);
            REG_RADIUS:   prdata = 64'(r_cfg.radius);
            REG_LIGHTPOS: prdata = 64'(r_cfg.light_pos);
            REG_ROW_X:    prdata = r_cfg.rows[0];
            REG_ROW_Y:    prdata = r_cfg.rows[1];
            REG_ROW_Z:    prdata = r_cfg.rows[2];
            default:      prdata = 64'd0;
        endcase
    end

    assign col_in = {i_sec_alpha, i_sec_blue, i_sec_green, i_sec_red,
                     i_pri_alpha, i_pri_blue, i_pri_green, i_pri_red};

    plsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pos   ({i_pos_z, i_pos_y, i_pos_x}),
        .i_col   (col_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    plsl_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    plsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_col   (col_out)
    );

    assign o_lit_pri_red   = col_out[7:0];
    assign o_lit_pri_green = col_out[15:8];
    assign o_lit_pri_blue  = col_out[23:16];
    assign o_lit_pri_alpha = col_out[31:24];
    assign o_lit_sec_red   = col_out[39:32];
    assign o_lit_sec_green = col_out[47:40];
    assign o_lit_sec_blue  = col_out[55:48];
    assign o_lit_sec_alpha = col_out[63:56];

endmodule

[hdl/plsl_front.sv]
module plsl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plsl_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [47:0]        i_pos,
    input  logic [63:0]        i_col,
    output logic               o_valid,
    input  logic               i_ready,
    output plsl_pkg::t_item    o_item
);
    import plsl_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_op   n_op;

    always_comb begin
        unique case (i_cfg.mode)
            MODE_AMBIENT: n_op = OP_AMBIENT;
            MODE_DIFFUSE: n_op = (i_cfg.radius == 16'd0) ? OP_AMBIENT : OP_DIFFUSE;
            default:      n_op = OP_PASS;
        endcase
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item.op  <= n_op;
            r_item.pos <= i_pos;
            r_item.col <= i_col;
        end
    end

endmodule

[hdl/plsl_queue.sv]
module plsl_queue #(
    parameter int DEPTH = plsl_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  plsl_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output plsl_pkg::t_item o_item
);
    import plsl_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)

endmodule

[hdl/plsl_back.sv]
module plsl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plsl_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  plsl_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_col
);
    import plsl_pkg::*;

    // Stage map: products, row sums, squares, length, 20 root steps,
    // reach check, 9 divide steps, light, modulate (output register).
    localparam int SP   = 0;
    localparam int SD   = 1;
    localparam int SS   = 2;
    localparam int SQ   = 3;
    localparam int SR0  = 4;
    localparam int RB   = 20;
    localparam int SC   = SR0 + RB;
    localparam int SV0  = SC + 1;
    localparam int AB   = 9;
    localparam int SL   = SV0 + AB;
    localparam int SM   = SL + 1;
    localparam int NSTG = SM + 1;

    typedef struct packed {
        t_op              op;
        logic [47:0]      pos;
        logic [63:0]      col;
        logic [8:0][31:0] prod;
        logic [2:0][19:0] d;
        logic [2:0][39:0] sq;
        logic [39:0]      rem;
        logic [RB-1:0]    root;
        logic [24:0]      drem;
        logic [AB-1:0]    attn;
        logic [3:0][16:0] light;
    } t_stage;

    t_stage            r_st [NSTG];
    t_stage            n_st [NSTG];
    logic [NSTG-1:0]   r_vld;
    logic              en;

    assign en      = !r_vld[NSTG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];
    assign o_col   = r_st[SM].col;

    always_comb begin
        logic signed [33:0] acc;
        logic signed [39:0] sqr;
        logic [40:0]        inc;
        logic [24:0]        dv;
        logic signed [18:0] lt;
        logic [7:0]         ca;
        logic [7:0]         cd;
        logic [7:0]         cc;
        logic [16:0]        am;
        logic [24:0]        dm;
        int                 b;

        n_st[SP]     = r_st[SP];
        n_st[SP].op  = i_item.op;
        n_st[SP].pos = i_item.pos;
        n_st[SP].col = i_item.col;
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                n_st[SP].prod[r*3+j] = $signed(i_cfg.rows[r][16*j +: 16])
                                     * $signed(i_item.pos[16*j +: 16]);
            end
        end
        for (int s = 1; s < NSTG; s++) begin
            n_st[s] = r_st[s-1];
        end

        // Transform each row, round half up to Q8.8, subtract the light.
        for (int r = 0; r < 3; r++) begin
            acc = 34'($signed(r_st[SD-1].prod[r*3]))
                + 34'($signed(r_st[SD-1].prod[r*3+1]))
                + 34'($signed(r_st[SD-1].prod[r*3+2]))
                + (34'($signed(i_cfg.rows[r][63:48])) <<< 14)
                + 34'sd8192;
            n_st[SD].d[r] = acc[33:14] - 20'($signed(i_cfg.light_pos[16*r +: 16]));
        end

        for (int r = 0; r < 3; r++) begin
            sqr = $signed(r_st[SS-1].d[r]) * $signed(r_st[SS-1].d[r]);
            n_st[SS].sq[r] = sqr;
        end

        n_st[SQ].rem  = r_st[SQ-1].sq[0] + r_st[SQ-1].sq[1] + r_st[SQ-1].sq[2];
        n_st[SQ].root = '0;

        // One root bit per stage, most significant first.
        for (int s = SR0; s < SC; s++) begin
            b   = RB - 1 - (s - SR0);
            inc = (41'(r_st[s-1].root) << (b + 1)) | (41'd1 << (2 * b));
            if ({1'b0, r_st[s-1].rem} >= inc) begin
                n_st[s].rem     = r_st[s-1].rem - inc[39:0];
                n_st[s].root[b] = 1'b1;
            end
        end

        if (r_st[SC-1].op == OP_DIFFUSE && r_st[SC-1].root > RB'(i_cfg.radius)) begin
            n_st[SC].op = OP_AMBIENT;
        end
        n_st[SC].drem = {1'b0, r_st[SC-1].root[15:0], 8'd0};
        n_st[SC].attn = '0;

        // Restoring division, one quotient bit per stage.
        for (int s = SV0; s < SL; s++) begin
            b  = AB - 1 - (s - SV0);
            dv = 25'(i_cfg.radius) << b;
            if (r_st[s-1].drem >= dv) begin
                n_st[s].drem    = r_st[s-1].drem - dv;
                n_st[s].attn[b] = 1'b1;
            end
        end

        for (int k = 0; k < 4; k++) begin
            ca = i_cfg.ambient[31-8*k -: 8];
            cd = i_cfg.diffuse[31-8*k -: 8];
            lt = $signed({3'd0, cd, 8'd0})
               + $signed({1'b0, r_st[SL-1].attn})
               * ($signed({1'b0, ca}) - $signed({1'b0, cd}));
            n_st[SL].light[k] = lt[16:0];
        end

        for (int i = 0; i < 8; i++) begin
            cc = r_st[SM-1].col[8*i +: 8];
            ca = i_cfg.ambient[31-8*(i & 3) -: 8];
            am = 17'(16'(cc) * 16'(ca)) + 17'd128;
            dm = 25'(cc) * 25'(r_st[SM-1].light[i & 3]) + 25'd128;
            case (r_st[SM-1].op)
                OP_AMBIENT: n_st[SM].col[8*i +: 8] = am[15:8];
                OP_DIFFUSE: n_st[SM].col[8*i +: 8] = dm[23:16];
                default:    n_st[SM].col[8*i +: 8] = cc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
        if (en) begin
            for (int s = 0; s < NSTG; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

`include "assert_macros.svh"
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !en, r_vld == $past(r_vld))
    `ASSERT_IMPLIES(a_root_rem, i_clk, i_rst_n, r_vld[SC], {1'b0, r_st[SC].rem} <= {20'd0, r_st[SC].root, 1'b0})

endmodule

[bench/tb_particle_simple_light_color.sv]
module tb_particle_simple_light_color;
    import plsl_pkg::*;

    typedef struct packed {
        logic [7:0] pr, pg, pb, pa, sr, sg, sb, sa;
    } t_colors;

    class lit_color_board;
        t_colors pending[$];
        int errors;

        function void note_request(t_colors c);
            pending.push_back(c);
        endfunction

        task check_result(t_colors got);
            t_colors want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, got);
            end else begin
                want = pending.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got[8*i +: 8] !== want[8*i +: 8]) begin
                        report_mismatch("channel differs", want[8*i +: 8], got[8*i +: 8]);
                    end
                end
            end
        endtask

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            $display("mismatch: %s want %h got %h", what, want, got);
            errors++;
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_ready;
    logic signed [15:0] pos_x = 0, pos_y = 0, pos_z = 0;
    t_colors     col_in = '0;
    logic        o_valid;
    logic        i_ready = 0;
    t_colors     col_out;

    // Shadow copy of the block's registers.
    logic [1:0]  sh_mode = 0;
    logic [31:0] sh_amb = 32'hFFFFFFFF, sh_dif = 0;
    logic [15:0] sh_rad = 0;
    logic [47:0] sh_lpos = 0;
    logic [63:0] sh_row[3] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};

    int send_idle = 11, recv_idle = 50;
    bit hold_off = 0;
    int quiet = 0;
    lit_color_board board = new();

    particle_simple_light_color dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_ready, .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_pri_red(col_in.pr), .i_pri_green(col_in.pg), .i_pri_blue(col_in.pb),
        .i_pri_alpha(col_in.pa), .i_sec_red(col_in.sr), .i_sec_green(col_in.sg),
        .i_sec_blue(col_in.sb), .i_sec_alpha(col_in.sa),
        .o_valid, .i_ready,
        .o_lit_pri_red(col_out.pr), .o_lit_pri_green(col_out.pg),
        .o_lit_pri_blue(col_out.pb), .o_lit_pri_alpha(col_out.pa),
        .o_lit_sec_red(col_out.sr), .o_lit_sec_green(col_out.sg),
        .o_lit_sec_blue(col_out.sb), .o_lit_sec_alpha(col_out.sa)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    function automatic logic signed [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] row_offset(logic [63:0] row,
            logic signed [15:0] px, py, pz, logic [15:0] lp);
        logic signed [63:0] acc;
        acc = sx16(row[15:0]) * px + sx16(row[31:16]) * py + sx16(row[47:32]) * pz
            + (sx16(row[63:48]) <<< 14) + 64'sd8192;
        return (acc >>> 14) - sx16(lp);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_colors light_colors(logic signed [15:0] px, py, pz, t_colors c);
        t_op op;
        logic signed [63:0] dx, dy, dz, a, d, attn;
        logic [63:0] reach, lt;
        t_colors r;
        op = OP_PASS;
        attn = 0;
        if (sh_mode == MODE_AMBIENT) begin
            op = OP_AMBIENT;
        end else if (sh_mode == MODE_DIFFUSE) begin
            if (sh_rad == 0) begin
                op = OP_AMBIENT;
            end else begin
                dx = row_offset(sh_row[0], px, py, pz, sh_lpos[15:0]);
                dy = row_offset(sh_row[1], px, py, pz, sh_lpos[31:16]);
                dz = row_offset(sh_row[2], px, py, pz, sh_lpos[47:32]);
                reach = int_sqrt(dx * dx + dy * dy + dz * dz);
                if (reach > sh_rad) begin
                    op = OP_AMBIENT;
                end else begin
                    op = OP_DIFFUSE;
                    attn = (reach * 256) / sh_rad;
                end
            end
        end
        r = c;
        // Struct bits 63:56 are primary red; channel k counts red first.
        for (int i = 0; i < 8; i++) begin
            a = 64'(sh_amb[24 - 8 * (i % 4) +: 8]);
            d = 64'(sh_dif[24 - 8 * (i % 4) +: 8]);
            if (op == OP_AMBIENT) begin
                r[56 - 8 * i +: 8] = 8'((c[56 - 8 * i +: 8] * a + 128) >> 8);
            end else if (op == OP_DIFFUSE) begin
                lt = d * 256 + attn * (a - d);
                r[56 - 8 * i +: 8] = 8'((c[56 - 8 * i +: 8] * lt + 128) >> 16);
            end
        end
        return r;
    endfunction

    task write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_MODE:     sh_mode = val[1:0];
            REG_AMBIENT:  sh_amb = val[31:0];
            REG_DIFFUSE:  sh_dif = val[31:0];
            REG_RADIUS:   sh_rad = val[15:0];
            REG_LIGHTPOS: sh_lpos = val[47:0];
            REG_ROW_X:    sh_row[0] = val;
            REG_ROW_Y:    sh_row[1] = val;
            REG_ROW_Z:    sh_row[2] = val;
        endcase
        @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back requests; drain drops it.
    task send_request(logic signed [15:0] x, y, z, t_colors c);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; pos_x <= x; pos_y <= y; pos_z <= z; col_in <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(light_colors(x, y, z, c));
    endtask

    task drain;
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // Small positions near the light so the diffuse branch is reached often.
    task send_random(int n, bit near);
        logic signed [15:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            if (near && $urandom_range(3) != 0) begin
                x = 16'($urandom_range(2047) - 1024);
                y = 16'($urandom_range(2047) - 1024);
                z = 16'($urandom_range(2047) - 1024);
            end else begin
                x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
            end
            send_request(x, y, z, {$urandom, $urandom});
        end
    endtask

    task random_config(logic [1:0] mode);
        write_reg(REG_MODE, mode);
        write_reg(REG_AMBIENT, $urandom);
        write_reg(REG_DIFFUSE, $urandom);
        write_reg(REG_RADIUS, $urandom_range(3) == 0 ? $urandom : $urandom_range(1500));
        write_reg(REG_LIGHTPOS, {$urandom, $urandom} & 64'h0000_01FF_01FF_01FF);
        write_reg(REG_ROW_X, $urandom_range(1) ? {$urandom, $urandom} : ROW_X_RESET);
        write_reg(REG_ROW_Y, $urandom_range(1) ? {$urandom, $urandom} : ROW_Y_RESET);
        write_reg(REG_ROW_Z, $urandom_range(1) ? {$urandom, $urandom} : ROW_Z_RESET);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_result(col_out);
    end

    always @(posedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Reset settings: pass-through.
        send_request(16'sh7FFF, -16'sh8000, 0, '1);
        send_request(0, 0, 0, '0);
        drain;
        write_reg(REG_MODE, 3);
        send_request(1, 2, 3, 64'h0123456789ABCDEF);
        drain;
        write_reg(REG_MODE, MODE_AMBIENT);
        write_reg(REG_AMBIENT, 32'h80FF0001);
        send_request(0, 0, 0, '1);
        send_request(0, 0, 0, 64'h7F7F7F7F01010101);
        drain;
        // Diffuse with zero radius falls back to ambient.
        write_reg(REG_MODE, MODE_DIFFUSE);
        write_reg(REG_RADIUS, 0);
        send_request(16'sh100, 0, 0, '1);
        drain;
        write_reg(REG_DIFFUSE, 32'h00FF8040);
        write_reg(REG_RADIUS, 16'h0100);
        write_reg(REG_LIGHTPOS, 48'h0);
        // Distance equal to radius, inside, beyond, and at the light.
        send_request(16'sh100, 0, 0, '1);
        send_request(16'sh080, 0, 0, '1);
        send_request(16'sh101, 0, 0, '1);
        send_request(0, 0, 0, 64'hFF00FF00FF00FF00);
        drain;
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_ROW_X, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_ROW_Y, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_LIGHTPOS, 48'h8000_7FFF_8000);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '1);
        send_request(-16'sh8000, -16'sh8000, -16'sh8000, '1);
        send_request(-16'sh8000, 16'sh7FFF, 0, '1);
        drain;

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 11 : (ph == 1) ? 50 : 0;
            recv_idle = (ph == 0) ? 50 : (ph == 1) ? 11 : 0;
            for (int s = 0; s < 4; s++) begin
                random_config(s == 3 ? 2'($urandom_range(3)) : MODE_DIFFUSE);
                if (ph == 1 && s == 0) begin
                    // Long receiver hold-off so the queue fills and input stalls.
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge i_clk);
                            hold_off = 0;
                        end
                        send_random(60, 1);
                    join
                    drain;
                end
                send_random(90, s != 2);
                drain;
            end
        end
        write_reg(REG_MODE, 0);
        send_random(10, 0);
        drain;
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
